/* hw/rtl/seq_timestamp_table_defines.svh */
// Assertion macros for the sent-segment timestamp table.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef SEQ_TIMESTAMP_TABLE_DEFINES_SVH
`define SEQ_TIMESTAMP_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define STT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/stt_pkg.sv */
// Shared types, constants and helpers for the sent-segment timestamp table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

   localparam int SEQ_W   = 32;
   localparam int TIME_W  = 48;
   localparam int BYTES_W = 32;
   localparam int MODE_W  = 3;
   localparam int COUNT_W = 7;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 96;
   localparam int RSP_PAD_W  = RSP_DATA_W - (1 + TIME_W + BYTES_W + COUNT_W + 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND      = 3'd0,
      MODE_REMOVE      = 3'd1,
      MODE_REMOVE_UPTO = 3'd2,
      MODE_FIRST       = 3'd3,
      MODE_LAST        = 3'd4,
      MODE_ADD_BYTES   = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [SEQ_W-1:0]   seq;
      logic [TIME_W-1:0]  stime;
      logic [BYTES_W-1:0] bytes;
   } entry_type;

   // Broadcast controls from the head unit to every cell.
   typedef struct packed {
      logic shift;
      logic wr;
   } cell_ctl_type;

   // Serial number order: a <= b when (b - a) mod 2^32 has its top bit clear.
   function automatic logic serial_le(input logic [SEQ_W-1:0] a,
                                      input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] diff;
      diff = b - a;
      return ~diff[SEQ_W-1];
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/stt_cell.sv */
// One slot of the table: holds an entry and its valid bit, shifts toward
// the head and takes a broadcast write at its own index. Uses stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_cell import stt_pkg::*; #(
   parameter int TABLE_DEPTH = 64,
   parameter int CELL_IDX    = 0
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire cell_ctl_type                     ctl,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0]   wr_idx,
   input  wire entry_type                        wr_entry,
   input  wire logic                             nb_valid,
   input  wire entry_type                        nb_entry,
   output logic                                  valid,
   output entry_type                             entry
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      hit_wr;

   assign hit_wr = ctl.wr && (wr_idx == MY_IDX);

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      // A write lands on the slot left free by the shift in the same cycle.
      if (hit_wr) begin
         valid_in = 1'b1;
         entry_in = wr_entry;
      end else if (ctl.shift) begin
         valid_in = nb_valid;
         entry_in = nb_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

`default_nettype wire

/* hw/rtl/stt_ctrl.sv */
// Head unit and sequencer: takes requests, rotates the chain of cells
// through the head, and registers the response. Uses stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_ctrl import stt_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [REQ_DATA_W-1:0]            req_tdata,
   input  wire logic [MODE_W-1:0]                req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [RSP_DATA_W-1:0]                 rsp_tdata,
   input  wire entry_type                        head_entry,
   output cell_ctl_type                          cell_ctl,
   output logic [$clog2(TABLE_DEPTH)-1:0]        wr_idx,
   output entry_type                             wr_entry
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   state_type          state_ff, state_in;
   mode_type           op_ff, op_in;
   logic [SEQ_W-1:0]   key_ff, key_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [BYTES_W-1:0] inc_ff, inc_in;
   logic [CNT_W-1:0]   steps_ff, steps_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               found_ff, found_in;
   logic [TIME_W-1:0]  stime_ff, stime_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic               hit_eq;
   logic               hit_le;
   logic               drop;
   logic [CNT_W-1:0]   cnt_dec;
   logic [CNT_W+COUNT_W-1:0] cnt_ext;

   assign hit_eq  = (head_entry.seq == key_ff);
   assign hit_le  = serial_le(head_entry.seq, key_ff);
   assign cnt_dec = count_ff - CNT_W'(1);
   assign cnt_ext = (CNT_W + COUNT_W)'(count_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      now_in       = now_ff;
      inc_in       = inc_ff;
      steps_in     = steps_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      stime_in     = stime_ff;
      bytes_in     = bytes_ff;
      ovf_in       = ovf_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      cell_ctl     = '0;
      wr_idx       = count_ff[IDX_W-1:0];
      wr_entry     = head_entry;
      drop         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in    = mode_type'(req_tuser);
               key_in   = req_tdata[SEQ_W-1:0];
               now_in   = req_tdata[SEQ_W +: TIME_W];
               inc_in   = req_tdata[SEQ_W+TIME_W +: BYTES_W];
               steps_in = count_ff;
               found_in = (mode_type'(req_tuser) == MODE_ADD_BYTES) && (count_ff != '0);
               stime_in = '0;
               bytes_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            case (op_ff)
               MODE_APPEND: begin
                  if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                     cell_ctl.wr    = 1'b1;
                     wr_idx         = count_ff[IDX_W-1:0];
                     wr_entry.seq   = key_ff;
                     wr_entry.stime = now_ff;
                     wr_entry.bytes = '0;
                     count_in       = count_ff + CNT_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  state_in = ST_DONE;
               end

               MODE_REMOVE, MODE_REMOVE_UPTO, MODE_FIRST, MODE_LAST, MODE_ADD_BYTES: begin
                  if (steps_ff == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     // Pop the head entry; unless it is removed, push it back
                     // at the tail so the original order is kept.
                     steps_in       = steps_ff - CNT_W'(1);
                     cell_ctl.shift = 1'b1;
                     if (op_ff == MODE_REMOVE) begin
                        drop = hit_eq;
                     end else if (op_ff == MODE_REMOVE_UPTO) begin
                        drop = hit_le;
                     end
                     if (drop) begin
                        found_in = 1'b1;
                        count_in = cnt_dec;
                     end else begin
                        cell_ctl.wr = 1'b1;
                        wr_idx      = cnt_dec[IDX_W-1:0];
                     end
                     if (op_ff == MODE_ADD_BYTES) begin
                        wr_entry.bytes = head_entry.bytes + inc_ff;
                     end
                     if (hit_eq && ((op_ff == MODE_LAST) ||
                                    ((op_ff == MODE_FIRST) && !found_ff))) begin
                        found_in = 1'b1;
                        stime_in = head_entry.stime;
                        bytes_in = head_entry.bytes;
                     end
                     if (steps_ff == CNT_W'(1)) begin
                        state_in = ST_DONE;
                     end
                  end
               end

               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {RSP_PAD_W'(0), ovf_ff, cnt_ext[COUNT_W-1:0],
                               bytes_ff, stime_ff, found_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      now_ff      <= now_in;
      inc_ff      <= inc_in;
      steps_ff    <= steps_in;
      found_ff    <= found_in;
      stime_ff    <= stime_in;
      bytes_ff    <= bytes_in;
      ovf_ff      <= ovf_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/seq_timestamp_table.sv */
// Top level of the sent-segment timestamp table: a chain of entry cells
// fed by the head unit. Uses stt_pkg, stt_cell, stt_ctrl and the defines header.
//
//   Channel  Direction  Payload
//   req_     in         tuser: mode; tdata: seq_number, now_time, byte_increment
//   rsp_     out        tdata: found, sent_time, byte_count, entry_count, overflow
//
// An append goes through ST_EXEC and ST_DONE once, and the next request is
// taken once ST_DONE has loaded the response. Every other mode rotates the n
// stored entries through the head cell, one per cycle, in ST_EXEC before
// ST_DONE; with n of zero it goes straight on to ST_DONE.
// Reset clears the valid bits and the entry count at once; no clearing pass.
// A new request is taken while the previous response waits in the output
// register; a stalled response holds back the next one and all later requests.
`timescale 1ns / 1ps
`default_nettype none
`include "seq_timestamp_table_defines.svh"

module seq_timestamp_table import stt_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // [31:0] seq_number, [79:32] now_time, [111:80] byte_increment
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,
   // [2:0] mode
   input  wire logic [MODE_W-1:0]       req_tuser,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // [0] found, [48:1] sent_time, [80:49] byte_count, [87:81] entry_count,
   // [88] overflow, [95:89] zero
   output logic [RSP_DATA_W-1:0]        rsp_tdata
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   cell_ctl_type     cell_ctl;
   logic [IDX_W-1:0] wr_idx;
   entry_type        wr_entry;
   logic             chain_valid [TABLE_DEPTH+1];
   entry_type        chain_entry [TABLE_DEPTH+1];

   // Past the last cell the chain reads as empty.
   assign chain_valid[TABLE_DEPTH] = 1'b0;
   assign chain_entry[TABLE_DEPTH] = '0;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      stt_cell #(
         .TABLE_DEPTH (TABLE_DEPTH),
         .CELL_IDX    (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl),
         .wr_idx   (wr_idx),
         .wr_entry (wr_entry),
         .nb_valid (chain_valid[g+1]),
         .nb_entry (chain_entry[g+1]),
         .valid    (chain_valid[g]),
         .entry    (chain_entry[g])
      );
   end

   stt_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .head_entry (chain_entry[0]),
      .cell_ctl   (cell_ctl),
      .wr_idx     (wr_idx),
      .wr_entry   (wr_entry)
   );

   `STT_ASSERT_NEXT(a_one_request_at_a_time, req_tvalid && req_tready, !req_tready, "request taken while busy")
   `STT_ASSERT_NOW(a_entries_packed, chain_valid[1], chain_valid[0], "table holds a gap at the head")
   `STT_ASSERT_NOW(a_overflow_not_found, rsp_tvalid && rsp_tdata[88], !rsp_tdata[0], "overflow reported with a match")

endmodule

`default_nettype wire

/* verif/tb_seq_timestamp_table.sv */
`timescale 1ns / 1ps
// Self-checking bench for seq_timestamp_table: directed and random table traffic,
// with each response checked against an in-bench model of the sent-segment table.
// Depends on stt_pkg and the seq_timestamp_table RTL only.

module tb_seq_timestamp_table;
   import stt_pkg::*;

   localparam int TBL_DEPTH    = 64;
   localparam int RANDOM_ITEMS = 1830;
   localparam int RECENT_N     = 32;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 2 * TBL_DEPTH + 10;
   localparam int CYCLE_LIMIT  = 1000000;

   // Codes six and seven have no operation behind them.
   localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [SEQ_W-1:0]   seq;
      logic [TIME_W-1:0]  now;
      logic [BYTES_W-1:0] inc;
   } seg_req_type;

   typedef struct packed {
      logic               found;
      logic [TIME_W-1:0]  stime;
      logic [BYTES_W-1:0] bytes;
      logic [COUNT_W-1:0] count;
      logic               overflow;
   } seg_rsp_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [MODE_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   seq_timestamp_table #(
      .TABLE_DEPTH(TBL_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Model of the table: valid entries packed at the low slots, oldest first.
   logic [SEQ_W-1:0]   tbl_seq   [TBL_DEPTH];
   logic [TIME_W-1:0]  tbl_time  [TBL_DEPTH];
   logic [BYTES_W-1:0] tbl_bytes [TBL_DEPTH];
   int                 tbl_used = 0;

   seg_req_type req_backlog[$];
   seg_rsp_type predicted_rsps[$];
   seg_req_type req_offer;
   seg_rsp_type rsp_want;
   seg_rsp_type rsp_got;

   int   req_accepted   = 0;
   int   total_items    = 0;
   int   rsp_seen       = 0;
   int   mismatches     = 0;
   int   found_seen     = 0;
   int   overflows_seen = 0;
   int   peak_used      = 0;
   int   cycle_count    = 0;
   int   hold_left      = 0;
   logic hold_done      = 1'b0;

   int traffic_phase;
   int send_idle_pct;
   int recv_idle_pct;

   assign traffic_phase = (req_accepted * 3 < total_items)     ? 0 :
                          (req_accepted * 3 < total_items * 2) ? 1 : 2;
   assign send_idle_pct = (traffic_phase == 0) ? 29 : (traffic_phase == 1) ? 50 : 0;
   assign recv_idle_pct = (traffic_phase == 0) ? 50 : (traffic_phase == 1) ? 29 : 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic seg_rsp_type apply_table_op(input seg_req_type r);
      seg_rsp_type      o;
      logic [SEQ_W-1:0] gap;
      logic             drop;
      int               keep;
      int               i;
      o = '0;
      case (r.mode)
         MODE_APPEND: begin
            if (tbl_used < TBL_DEPTH) begin
               tbl_seq[tbl_used]   = r.seq;
               tbl_time[tbl_used]  = r.now;
               tbl_bytes[tbl_used] = '0;
               tbl_used++;
            end else begin
               o.overflow = 1'b1;
            end
         end
         MODE_REMOVE, MODE_REMOVE_UPTO: begin
            keep = 0;
            for (i = 0; i < tbl_used; i++) begin
               // An entry is at or before the bound when the forward distance
               // to the bound is less than half the sequence space.
               gap  = r.seq - tbl_seq[i];
               drop = (r.mode == MODE_REMOVE) ? (gap == '0) : !gap[SEQ_W-1];
               if (drop) begin
                  o.found = 1'b1;
               end else begin
                  tbl_seq[keep]   = tbl_seq[i];
                  tbl_time[keep]  = tbl_time[i];
                  tbl_bytes[keep] = tbl_bytes[i];
                  keep++;
               end
            end
            tbl_used = keep;
         end
         MODE_FIRST: begin
            // Walk from the newest end so the oldest match is written last.
            for (i = tbl_used - 1; i >= 0; i--) begin
               if (tbl_seq[i] == r.seq) begin
                  o.found = 1'b1;
                  o.stime = tbl_time[i];
                  o.bytes = tbl_bytes[i];
               end
            end
         end
         MODE_LAST: begin
            for (i = 0; i < tbl_used; i++) begin
               if (tbl_seq[i] == r.seq) begin
                  o.found = 1'b1;
                  o.stime = tbl_time[i];
                  o.bytes = tbl_bytes[i];
               end
            end
         end
         MODE_ADD_BYTES: begin
            for (i = 0; i < tbl_used; i++) begin
               tbl_bytes[i] = tbl_bytes[i] + r.inc;
            end
            o.found = (tbl_used > 0);
         end
         default: begin
         end
      endcase
      o.count = tbl_used[COUNT_W-1:0];
      return o;
   endfunction

   function automatic void add_req(input logic [MODE_W-1:0] mode, input logic [SEQ_W-1:0] seq,
                                   input logic [TIME_W-1:0] now, input logic [BYTES_W-1:0] inc);
      seg_req_type r;
      r.mode = mode;
      r.seq  = seq;
      r.now  = now;
      r.inc  = inc;
      req_backlog.insert(req_backlog.size(), r);
   endfunction

   // Random traffic in bursts: fill bursts push the table to full and past it,
   // mixed bursts exercise every operation, drain bursts empty the table again.
   task automatic plan_random(input int n_items);
      logic [SEQ_W-1:0]   recent [RECENT_N];
      logic [SEQ_W-1:0]   next_seq;
      logic [SEQ_W-1:0]   key;
      logic [BYTES_W-1:0] inc;
      logic [TIME_W-1:0]  now;
      logic [MODE_W-1:0]  mode;
      int                 recent_fill;
      int                 recent_wr;
      int                 burst_kind;
      int                 burst_left;
      int                 roll;
      int                 i;
      next_seq    = $urandom;
      recent_fill = 0;
      recent_wr   = 0;
      burst_kind  = 0;
      burst_left  = 0;
      for (i = 0; i < n_items; i++) begin
         if (burst_left == 0) begin
            burst_kind = $urandom_range(2);
            burst_left = (burst_kind == 0) ? $urandom_range(60, 110) : $urandom_range(20, 60);
         end
         burst_left--;
         roll = $urandom_range(99);
         if (burst_kind == 0) begin
            if (roll < 85)      mode = MODE_APPEND;
            else if (roll < 93) mode = MODE_FIRST;
            else                mode = MODE_LAST;
         end else if (burst_kind == 1) begin
            if (roll < 35)      mode = MODE_APPEND;
            else if (roll < 50) mode = MODE_FIRST;
            else if (roll < 65) mode = MODE_LAST;
            else if (roll < 75) mode = MODE_REMOVE;
            else if (roll < 83) mode = MODE_REMOVE_UPTO;
            else if (roll < 98) mode = MODE_ADD_BYTES;
            else if (roll < 99) mode = MODE_SPARE_6;
            else                mode = MODE_SPARE_7;
         end else begin
            if (roll < 35)      mode = MODE_REMOVE_UPTO;
            else if (roll < 60) mode = MODE_REMOVE;
            else if (roll < 72) mode = MODE_FIRST;
            else if (roll < 84) mode = MODE_LAST;
            else if (roll < 92) mode = MODE_ADD_BYTES;
            else if (roll < 96) mode = MODE_APPEND;
            else if (roll < 98) mode = MODE_SPARE_6;
            else                mode = MODE_SPARE_7;
         end

         if (recent_fill != 0 && $urandom_range(3) != 0) begin
            key = recent[$urandom_range(recent_fill - 1)];
         end else begin
            key = $urandom;
         end
         if (mode == MODE_APPEND) begin
            // Most appends take a fresh number; some repeat an earlier one.
            if (recent_fill == 0 || $urandom_range(7) != 0) begin
               key = next_seq;
               case ($urandom_range(31))
                  0:       next_seq = $urandom;
                  1:       next_seq = 32'hFFFF_FFFF - $urandom_range(4000);
                  default: next_seq = next_seq + $urandom_range(1, 1460);
               endcase
            end
            recent[recent_wr] = key;
            recent_wr = (recent_wr + 1) % RECENT_N;
            if (recent_fill < RECENT_N) recent_fill++;
         end

         case ($urandom_range(3))
            0:       inc = $urandom_range(1500);
            1:       inc = 32'hFFFF_FFFF - $urandom_range(1000);
            default: inc = $urandom;
         endcase
         now = TIME_W'({$urandom, $urandom});
         add_req(mode, key, now, inc);
      end
   endtask

   task automatic check_field(input string fname, input int idx,
                              input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("response %0d: %s expected 0x%0h, got 0x%0h", idx, fname, want, got);
         end
      end
   endtask

   // Request driver: the handshake also feeds the model, in acceptance order.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_rsps.insert(predicted_rsps.size(), apply_table_op(req_offer));
            req_accepted <= req_accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_offer = req_backlog.pop_front();
               req_tdata  <= {req_offer.inc, req_offer.now, req_offer.seq};
               req_tuser  <= req_offer.mode;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response ready, with one long hold-off at the start of the last phase
   // so that the block backs up and stalls its request side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!hold_done && traffic_phase == 2) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_got.found    = rsp_tdata[0];
         rsp_got.stime    = rsp_tdata[48:1];
         rsp_got.bytes    = rsp_tdata[80:49];
         rsp_got.count    = rsp_tdata[87:81];
         rsp_got.overflow = rsp_tdata[88];
         if (predicted_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response %0d arrived with nothing predicted", rsp_seen);
            end
         end else begin
            rsp_want = predicted_rsps.pop_front();
            check_field("found", rsp_seen, 64'(rsp_want.found), 64'(rsp_got.found));
            check_field("sent_time", rsp_seen, 64'(rsp_want.stime), 64'(rsp_got.stime));
            check_field("byte_count", rsp_seen, 64'(rsp_want.bytes), 64'(rsp_got.bytes));
            check_field("entry_count", rsp_seen, 64'(rsp_want.count), 64'(rsp_got.count));
            check_field("overflow", rsp_seen, 64'(rsp_want.overflow),
                        64'(rsp_got.overflow));
         end
         if (rsp_got.found) found_seen++;
         if (rsp_got.overflow) overflows_seen++;
         if (int'(rsp_got.count) > peak_used) peak_used = int'(rsp_got.count);
         rsp_seen++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d responses seen",
                  cycle_count, rsp_seen, total_items);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      // Empty table: every lookup and removal misses, add bytes finds nothing.
      add_req(MODE_FIRST, 32'h0000_0000, 48'h0, 32'h0);
      add_req(MODE_LAST, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      add_req(MODE_REMOVE, 32'h0000_0000, 48'h0, 32'h0);
      add_req(MODE_REMOVE_UPTO, 32'hFFFF_FFFF, 48'h0, 32'h0);
      add_req(MODE_ADD_BYTES, 32'h0000_0000, 48'h0, 32'hFFFF_FFFF);
      // Extremes of sequence and time, with a repeated sequence number.
      add_req(MODE_APPEND, 32'h0000_0000, 48'h0, 32'hFFFF_FFFF);
      add_req(MODE_APPEND, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0);
      add_req(MODE_APPEND, 32'h8000_0000, 48'h5555_5555_5555, 32'h0);
      add_req(MODE_APPEND, 32'h0000_0000, 48'hAAAA_AAAA_AAAA, 32'h0);
      // Counters wrap: all ones plus two leaves one.
      add_req(MODE_ADD_BYTES, 32'h0, 48'h0, 32'hFFFF_FFFF);
      add_req(MODE_ADD_BYTES, 32'h0, 48'h0, 32'h0000_0002);
      add_req(MODE_ADD_BYTES, 32'h0, 48'h0, 32'h0000_0000);
      add_req(MODE_FIRST, 32'h0000_0000, 48'h0, 32'h0);
      add_req(MODE_LAST, 32'h0000_0000, 48'h0, 32'h0);
      add_req(MODE_FIRST, 32'hFFFF_FFFF, 48'h0, 32'h0);
      add_req(MODE_LAST, 32'h0001_2345, 48'h0, 32'h0);
      add_req(MODE_SPARE_6, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      add_req(MODE_SPARE_7, 32'h0000_0000, 48'h0, 32'h0);
      add_req(MODE_REMOVE, 32'h0000_0000, 48'h0, 32'h0);
      add_req(MODE_REMOVE, 32'h0001_2345, 48'h0, 32'h0);
      // Serial bounds: the first catches nothing, the next two each take one.
      add_req(MODE_REMOVE_UPTO, 32'h7FFF_FFFF, 48'h0, 32'h0);
      add_req(MODE_REMOVE_UPTO, 32'h0000_0005, 48'h0, 32'h0);
      add_req(MODE_REMOVE_UPTO, 32'h8000_0000, 48'h0, 32'h0);
      add_req(MODE_FIRST, 32'h8000_0000, 48'h0, 32'h0);
      plan_random(RANDOM_ITEMS);
      total_items = req_backlog.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (rsp_seen < total_items) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (predicted_rsps.size() != 0) begin
         mismatches += predicted_rsps.size();
         $display("%0d predicted responses never arrived", predicted_rsps.size());
      end

      $display("Ran %0d requests through all six operations and the spare codes;",
               total_items);
      $display("%0d responses had found set, %0d appends were dropped, peak fill %0d of %0d.",
               found_seen, overflows_seen, peak_used, TBL_DEPTH);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/stt_pkg.sv
hw/rtl/stt_cell.sv
hw/rtl/stt_ctrl.sv
hw/rtl/seq_timestamp_table.sv
verif/tb_seq_timestamp_table.sv
